[design/trle_pkg.sv]
package trle_pkg;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT     = 1'd1;

	localparam logic [7:0] RUN_HEADER_MIN = 8'd128;
	localparam logic [7:0] RUN_BIAS       = 8'd127;

	localparam logic [2:0] BPP_RESET   = 3'd4;
	localparam logic [31:0] PIXEL_COUNT_RESET = 32'd1;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_RAW    = 3'b010,
		PH_RUN    = 3'b100
	} phase_t;

	typedef struct packed {
		logic [31:0] pixel_value;
		logic [7:0]  repeat_count;
		logic        image_end;
		logic        overrun;
	} pixel_run_t;

endpackage

[design/trle_stream_if.sv]
interface trle_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface trle_run_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_value;
	logic [7:0]  repeat_count;
	logic        image_end;
	logic        overrun;

	modport source (output valid, output pixel_value, output repeat_count,
		output image_end, output overrun, input ready);
	modport sink (input valid, input pixel_value, input repeat_count,
		input image_end, input overrun, output ready);
endinterface

[design/tga_rle_pixel_decoder_core.sv]
// Run-length pixel decoder for the compressed pixel stream of a TGA image.
// Coded bytes arrive on in_bytes, one item per byte. Header bytes open raw
// or run packets; pixel bytes are gathered into one word, first byte in
// bits 7:0. Each completed pixel leaves on out_runs as one item with its
// repeat count, an end-of-image mark and an overrun flag for a clipped packet.
// A byte is taken in every cycle while the output register is empty or is
// being emptied in the same cycle, so the sustained rate is one byte per
// cycle. The result of the last byte of a pixel is valid on the next cycle.
// When the receiver stalls, the one result register holds its item and
// in_bytes.ready drops until that item is taken; no item is lost.
// The configuration port writes bytes_per_pixel (index 0) and pixel_count
// (index 1); write it only while the decoder is idle. pixel_count is loaded
// at the start of each image.
// Reset sets bytes_per_pixel to 4 and pixel_count to 1, empties the output
// register and makes the next byte the first header of a new image.
module tga_rle_pixel_decoder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            write_en,
	input  logic [trle_pkg::CFG_INDEX_W-1:0] write_index,
	input  logic [trle_pkg::CFG_DATA_W-1:0]  write_data,
	trle_byte_if.sink                       in_bytes,
	trle_run_if.source                      out_runs
);
	import trle_pkg::*;

	logic [2:0]  bytes_per_pixel_q;
	logic [31:0] pixel_count_q;

	phase_t      phase_q, phase_d;
	logic [7:0]  packet_left_q, packet_left_d;
	logic [1:0]  byte_index_q, byte_index_d;
	logic [31:0] pixel_gather_q, pixel_gather_d;
	logic [31:0] pixels_left_q, pixels_left_d;

	logic        out_valid_q;
	pixel_run_t  out_q, result_d;
	logic        result_valid_d;

	logic        accept;
	logic [2:0]  eff_bpp;
	logic [2:0]  next_count;
	logic [31:0] packet_left_w;
	logic [7:0]  data_b;

	assign data_b = in_bytes.data_byte;
	assign in_bytes.ready = !out_valid_q || out_runs.ready;
	assign accept = in_bytes.valid && in_bytes.ready;

	always_comb begin
		if (bytes_per_pixel_q == 3'd0) begin
			eff_bpp = 3'd1;
		end else if (bytes_per_pixel_q > 3'd4) begin
			eff_bpp = 3'd4;
		end else begin
			eff_bpp = bytes_per_pixel_q;
		end
	end

	assign next_count = {1'b0, byte_index_q} + 3'd1;
	assign packet_left_w = {24'd0, packet_left_q};

	always_comb begin
		phase_d        = phase_q;
		packet_left_d  = packet_left_q;
		byte_index_d   = byte_index_q;
		pixel_gather_d = pixel_gather_q;
		pixels_left_d  = pixels_left_q;
		result_valid_d = 1'b0;
		result_d       = '0;

		if (phase_q != PH_RAW && phase_q != PH_RUN) begin
			if (pixels_left_q == 32'd0) begin
				pixels_left_d = (pixel_count_q == 32'd0) ? 32'd1 : pixel_count_q;
			end
			if (data_b < RUN_HEADER_MIN) begin
				phase_d       = PH_RAW;
				packet_left_d = data_b + 8'd1;
			end else begin
				phase_d       = PH_RUN;
				packet_left_d = data_b - RUN_BIAS;
			end
			byte_index_d   = 2'd0;
			pixel_gather_d = 32'd0;
		end else begin
			pixel_gather_d = ((byte_index_q == 2'd0) ? 32'd0 : pixel_gather_q)
				| ({24'd0, data_b} << {byte_index_q, 3'b000});
			if (next_count < eff_bpp) begin
				byte_index_d = byte_index_q + 2'd1;
			end else begin
				byte_index_d          = 2'd0;
				result_valid_d        = 1'b1;
				result_d.pixel_value  = pixel_gather_d;
				if (phase_q == PH_RAW) begin
					result_d.repeat_count = 8'd1;
					result_d.image_end    = (pixels_left_q <= 32'd1);
					result_d.overrun      = result_d.image_end && (packet_left_q > 8'd1);
					pixels_left_d = result_d.image_end ? 32'd0 : pixels_left_q - 32'd1;
					packet_left_d = (packet_left_q > 8'd0) ? packet_left_q - 8'd1 : 8'd0;
					if (result_d.image_end || packet_left_d == 8'd0) begin
						phase_d       = PH_HEADER;
						packet_left_d = 8'd0;
					end
				end else begin
					if (packet_left_w >= pixels_left_q) begin
						result_d.repeat_count = pixels_left_q[7:0];
						result_d.image_end    = 1'b1;
						result_d.overrun      = (packet_left_w > pixels_left_q);
						pixels_left_d         = 32'd0;
					end else begin
						result_d.repeat_count = packet_left_q;
						result_d.image_end    = 1'b0;
						result_d.overrun      = 1'b0;
						pixels_left_d         = pixels_left_q - packet_left_w;
					end
					phase_d       = PH_HEADER;
					packet_left_d = 8'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_pixel_q <= BPP_RESET;
			pixel_count_q     <= PIXEL_COUNT_RESET;
		end else if (write_en) begin
			case (write_index)
				REG_BYTES_PER_PIXEL: bytes_per_pixel_q <= write_data[2:0];
				REG_PIXEL_COUNT:     pixel_count_q     <= write_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			packet_left_q  <= 8'd0;
			byte_index_q   <= 2'd0;
			pixel_gather_q <= 32'd0;
			pixels_left_q  <= 32'd0;
		end else if (accept) begin
			phase_q        <= phase_d;
			packet_left_q  <= packet_left_d;
			byte_index_q   <= byte_index_d;
			pixel_gather_q <= pixel_gather_d;
			pixels_left_q  <= pixels_left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= result_valid_d;
		end else if (out_runs.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && result_valid_d) begin
			out_q <= result_d;
		end
	end

	assign out_runs.valid        = out_valid_q;
	assign out_runs.pixel_value  = out_q.pixel_value;
	assign out_runs.repeat_count = out_q.repeat_count;
	assign out_runs.image_end    = out_q.image_end;
	assign out_runs.overrun      = out_q.overrun;

endmodule
